FILE: rtl/ptrs_pkg.sv
`default_nettype none

package ptrs_pkg;

    // Table depth and derived widths
    localparam int TASKS     = 8;
    localparam int CNT_W     = $clog2(TASKS + 1);
    localparam int SLOT_W    = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int MASK_BITS = 8;

    // Field widths
    localparam int TICK_W    = 32;
    localparam int PER_W     = 16;
    localparam int DIV_STEPS = TICK_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    // Status returned by the remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } rem_res_t;

endpackage

`default_nettype wire

FILE: rtl/ptrs_rem_unit.sv
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle.
module ptrs_rem_unit
    import ptrs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] dividend,
    input  wire logic [PER_W-1:0]  divisor,
    output rem_res_t               res
);

    typedef enum logic {
        RS_IDLE,
        RS_RUN
    } rs_state_t;

    rs_state_t           state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TICK_W-1:0]   dvd_reg;
    logic [PER_W-1:0]    dsr_reg;
    logic [PER_W-1:0]    rem_reg;
    logic                done_reg;
    logic                zero_reg;

    logic [PER_W:0]      rem_sh;
    logic [PER_W+1:0]    diff;
    logic [PER_W-1:0]    rem_next;

    always_comb begin
        rem_sh = {rem_reg, dvd_reg[TICK_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
        if (diff[PER_W+1]) begin
            rem_next = rem_sh[PER_W-1:0];
        end else begin
            rem_next = diff[PER_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RS_IDLE;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                RS_IDLE: begin
                    if (start) begin
                        dvd_reg   <= dividend;
                        dsr_reg   <= divisor;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= RS_RUN;
                    end
                end
                RS_RUN: begin
                    rem_reg  <= rem_next;
                    dvd_reg  <= {dvd_reg[TICK_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        done_reg  <= 1'b1;
                        zero_reg  <= (rem_next == '0);
                        state_reg <= RS_IDLE;
                    end
                end
                default: state_reg <= RS_IDLE;
            endcase
        end
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg == RS_RUN))
        else $error("remainder done without a run");

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RS_RUN) |-> !start)
        else $error("remainder started while busy");

    a_run_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == RS_IDLE))
        else $error("remainder still running after done");

endmodule

`default_nettype wire

FILE: rtl/periodic_task_release_scheduler_unit.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_action, s_task_period, s_task_offset
// m_       out        m_valid / m_ready   m_due_mask, m_add_rejected, m_tick_now
//
// Add, clear and unused actions pass from accept to the post state and then into
// the result register, where the transaction can be taken downstream.
// A tick walks the table slot by slot: each stored task costs one table read,
// one setup state and a wait on the bit-serial remainder unit (32 steps plus
// the done handoff); a task with zero period skips the remainder and costs only
// the read and setup states.
// Reset (aresetn low, synchronous) empties the table and zeroes the tick count.
// One transaction is worked at a time; a finished result waits in the output
// register and the next transaction is accepted while it waits.
module periodic_task_release_scheduler_unit
    import ptrs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_action,
    input  wire logic [PER_W-1:0]     s_task_period,
    input  wire logic [PER_W-1:0]     s_task_offset,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [MASK_BITS-1:0]      m_due_mask,
    output logic                      m_add_rejected,
    output logic [TICK_W-1:0]         m_tick_now
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_WAIT,
        ST_POST
    } state_t;

    state_t                state_reg;
    logic [TICK_W-1:0]     tick_count_reg;
    logic [CNT_W-1:0]      task_total_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [MASK_BITS-1:0]  mask_reg;
    logic                  rej_reg;

    // Result register
    logic                  m_valid_reg;
    logic [MASK_BITS-1:0]  due_mask_reg;
    logic                  add_rejected_reg;
    logic [TICK_W-1:0]     tick_now_reg;

    // Task table, one write port and one registered read port
    logic [PER_W-1:0]      period_mem [TASKS];
    logic [PER_W-1:0]      offset_mem [TASKS];
    logic [PER_W-1:0]      per_rd_reg;
    logic [PER_W-1:0]      off_rd_reg;

    logic                  accept;
    logic                  table_full;
    logic                  mem_we;
    logic                  rem_start;
    logic [TICK_W-1:0]     rem_dividend;
    rem_res_t              rem_res;
    logic [CNT_W-1:0]      slot_inc;
    logic                  slot_more;
    logic                  out_free;
    logic [MASK_BITS-1:0]  mask_set;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign table_full = (task_total_reg == CNT_W'(TASKS));
    assign mem_we     = accept && (s_action == ACT_ADD) && !table_full;
    assign out_free   = !m_valid_reg || m_ready;

    assign slot_inc   = CNT_W'(slot_reg) + 1'b1;
    assign slot_more  = (slot_inc < task_total_reg);

    // Release test of the current slot: (tick - offset) mod period
    assign rem_start    = (state_reg == ST_START) && (per_rd_reg != '0);
    assign rem_dividend = tick_count_reg - {{(TICK_W-PER_W){1'b0}}, off_rd_reg};

    // Mark the current slot's bit; slots beyond the mask width have none
    always_comb begin
        mask_set = '0;
        for (int b = 0; b < MASK_BITS; b++) begin
            if ((b < TASKS) && (slot_reg == SLOT_W'(b))) begin
                mask_set[b] = 1'b1;
            end
        end
    end

    ptrs_rem_unit u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (per_rd_reg),
        .res      (rem_res)
    );

    // Table write on add, read of the slot being tested every cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            period_mem[task_total_reg[SLOT_W-1:0]] <= s_task_period;
            offset_mem[task_total_reg[SLOT_W-1:0]] <= s_task_offset;
        end
        per_rd_reg <= period_mem[slot_reg];
        off_rd_reg <= offset_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            task_total_reg <= '0;
            slot_reg       <= '0;
            mask_reg       <= '0;
            rej_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // Drop the result once the downstream side takes it, unless the
            // post state reloads the register at the same edge
            if (m_valid_reg && m_ready && (state_reg != ST_POST)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mask_reg <= '0;
                        rej_reg  <= 1'b0;
                        slot_reg <= '0;
                        state_reg <= ST_POST;
                        unique case (s_action)
                            ACT_TICK: begin
                                // Advance the count, then walk the table
                                tick_count_reg <= tick_count_reg + 1'b1;
                                if (task_total_reg != '0) begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            ACT_ADD: begin
                                if (table_full) begin
                                    rej_reg <= 1'b1;
                                end else begin
                                    task_total_reg <= task_total_reg + 1'b1;
                                end
                            end
                            ACT_CLEAR: begin
                                task_total_reg <= '0;
                                tick_count_reg <= '0;
                            end
                            default: begin
                                // Unused code: hold everything
                            end
                        endcase
                    end
                end
                ST_FETCH: begin
                    // Table read lands in per_rd_reg / off_rd_reg
                    state_reg <= ST_START;
                end
                ST_START: begin
                    if (per_rd_reg != '0) begin
                        state_reg <= ST_WAIT;
                    end else if (slot_more) begin
                        // Zero period: never due, skip to the next slot
                        slot_reg  <= SLOT_W'(slot_inc);
                        state_reg <= ST_FETCH;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_WAIT: begin
                    if (rem_res.done) begin
                        if (rem_res.zero) begin
                            mask_reg <= mask_reg | mask_set;
                        end
                        if (slot_more) begin
                            slot_reg  <= SLOT_W'(slot_inc);
                            state_reg <= ST_FETCH;
                        end else begin
                            state_reg <= ST_POST;
                        end
                    end
                end
                ST_POST: begin
                    // Load the result register once it is free
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        due_mask_reg     <= mask_reg;
                        add_rejected_reg <= rej_reg;
                        tick_now_reg     <= tick_count_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_due_mask     = due_mask_reg;
    assign m_add_rejected = add_rejected_reg;
    assign m_tick_now     = tick_now_reg;

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        task_total_reg <= CNT_W'(TASKS))
        else $error("task count beyond table depth");

    a_full_add_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_action == ACT_ADD) && table_full)
            |=> (task_total_reg == $past(task_total_reg)) && rej_reg)
        else $error("add into full table changed the count");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_res.done |-> (state_reg == ST_WAIT))
        else $error("remainder finished outside the wait state");

    a_load_from_post: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_POST))
        else $error("result loaded outside the post state");

endmodule

`default_nettype wire
